FILE: rtl/fplc_pkg.sv
// Shared types and constants of the field pixel line classifier.
// Holds the configuration register map, reset values and field widths.
// No dependencies; fplc_pix_if and the core import this package.
`default_nettype none

package fplc_pkg;

  localparam int unsigned ChanW   = 8;   // width of one color channel
  localparam int unsigned ShareW  = 7;   // width of a share threshold in hundredths
  localparam int unsigned RunW    = 3;   // width of the green run counter
  localparam int unsigned SumW    = 10;  // red + grn + blue
  localparam int unsigned PixProdW = 15; // 100 * channel
  localparam int unsigned ThrProdW = 17; // share threshold * channel sum
  localparam int unsigned ExcessW = 11;  // both sides of the green excess test
  localparam int unsigned AddrW   = 5;
  localparam int unsigned DataW   = 32;

  localparam logic [RunW-1:0]     RunLimit   = 3'd5;
  localparam logic [RunW-1:0]     RunMax     = 3'd7;
  localparam logic [ShareW-1:0]   Hundred    = 7'd100;

  // Register index, taken from paddr[4:2].
  typedef enum logic [2:0] {
    REG_NORM_RED_MIN     = 3'd0,
    REG_NORM_GREEN_MIN   = 3'd1,
    REG_NORM_BLUE_MAX    = 3'd2,
    REG_ABS_RED_MIN      = 3'd3,
    REG_ABS_GREEN_MIN    = 3'd4,
    REG_ABS_BLUE_MAX     = 3'd5,
    REG_WHITE_MIN        = 3'd6,
    REG_GREEN_EXCESS_MIN = 3'd7
  } reg_idx_t;

  localparam logic [ShareW-1:0] RstNormRedMin    = 7'd38;
  localparam logic [ShareW-1:0] RstNormGreenMin  = 7'd38;
  localparam logic [ShareW-1:0] RstNormBlueMax   = 7'd20;
  localparam logic [ChanW-1:0]  RstAbsRedMin     = 8'd230;
  localparam logic [ChanW-1:0]  RstAbsGreenMin   = 8'd230;
  localparam logic [ChanW-1:0]  RstAbsBlueMax    = 8'd160;
  localparam logic [ChanW-1:0]  RstWhiteMin      = 8'd200;
  localparam logic [ChanW-1:0]  RstGreenExcessMin = 8'd34;

endpackage

`default_nettype wire

FILE: rtl/fplc_pix_if.sv
// Pixel input channel of the field pixel line classifier.
// Valid/ready handshake with the pixel channels and column start flag.
// Depends on fplc_pkg for the channel width.
`default_nettype none

interface fplc_pix_if import fplc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ChanW-1:0] red;
  logic [ChanW-1:0] grn;
  logic [ChanW-1:0] blue;
  logic             column_start;

  modport source (output valid, red, grn, blue, column_start, input ready);
  modport sink   (input valid, red, grn, blue, column_start, output ready);
endinterface

`default_nettype wire

FILE: rtl/fplc_res_if.sv
// Result channel of the field pixel line classifier.
// Valid/ready handshake with the three classification flags of one pixel.
// No package dependency.
`default_nettype none

interface fplc_res_if;
  logic valid;
  logic ready;
  logic line_white;
  logic yellow_mask;
  logic field_green;

  modport source (output valid, line_white, yellow_mask, field_green, input ready);
  modport sink   (input valid, line_white, yellow_mask, field_green, output ready);
endinterface

`default_nettype wire

FILE: rtl/field_pixel_line_classifier_core.sv
// Top level of the field pixel line classifier.
// Depends on fplc_pkg and on the interfaces fplc_pix_if and fplc_res_if.
//
// Usage:
//   Pixels arrive column by column on in_pix, one transaction per pixel, with
//   column_start high on the first pixel of each column. Every pixel yields
//   exactly one result transaction on out_res, in order.
//   A pixel passes the stage one registers and then the result register,
//   which drives out_res.valid. The block takes one pixel per clock while
//   out_res.ready stays high: the first stage registers the share products
//   and the threshold compares, the second applies the per-column run state
//   and loads the result register. The six small multipliers of the share
//   test sit in the first stage; nothing else limits the rate.
//   When the receiver stalls, the result register holds, the first stage
//   fills behind it, and in_pix.ready drops until out_res.ready returns.
//   Reset (rst_n low, synchronous) empties both stages, restores the register
//   defaults and puts the column state at the start of a column.
//   APB writes the eight thresholds at byte address 4*index; pready is always
//   high. The user writes only while no pixel is in flight; no check enforces it.
`default_nettype none

module field_pixel_line_classifier_core import fplc_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  fplc_pix_if.sink               in_pix,
  fplc_res_if.source             out_res,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [AddrW-1:0]  cfg_paddr,
  input  wire logic [DataW-1:0]  cfg_pwdata,
  output logic      [DataW-1:0]  cfg_prdata,
  output logic                   cfg_pready
);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [ShareW-1:0] norm_red_min_r, norm_green_min_r, norm_blue_max_r;
  logic [ChanW-1:0]  abs_red_min_r, abs_green_min_r, abs_blue_max_r;
  logic [ChanW-1:0]  white_min_r, green_excess_min_r;
  reg_idx_t          cfg_idx;
  logic              cfg_wr;

  assign cfg_idx    = reg_idx_t'(cfg_paddr[4:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      norm_red_min_r     <= RstNormRedMin;
      norm_green_min_r   <= RstNormGreenMin;
      norm_blue_max_r    <= RstNormBlueMax;
      abs_red_min_r      <= RstAbsRedMin;
      abs_green_min_r    <= RstAbsGreenMin;
      abs_blue_max_r     <= RstAbsBlueMax;
      white_min_r        <= RstWhiteMin;
      green_excess_min_r <= RstGreenExcessMin;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_NORM_RED_MIN:     norm_red_min_r     <= cfg_pwdata[ShareW-1:0];
        REG_NORM_GREEN_MIN:   norm_green_min_r   <= cfg_pwdata[ShareW-1:0];
        REG_NORM_BLUE_MAX:    norm_blue_max_r    <= cfg_pwdata[ShareW-1:0];
        REG_ABS_RED_MIN:      abs_red_min_r      <= cfg_pwdata[ChanW-1:0];
        REG_ABS_GREEN_MIN:    abs_green_min_r    <= cfg_pwdata[ChanW-1:0];
        REG_ABS_BLUE_MAX:     abs_blue_max_r     <= cfg_pwdata[ChanW-1:0];
        REG_WHITE_MIN:        white_min_r        <= cfg_pwdata[ChanW-1:0];
        REG_GREEN_EXCESS_MIN: green_excess_min_r <= cfg_pwdata[ChanW-1:0];
        default:              ;
      endcase
    end
  end

  always_comb begin
    cfg_prdata = '0;
    unique case (cfg_idx)
      REG_NORM_RED_MIN:     cfg_prdata = DataW'(norm_red_min_r);
      REG_NORM_GREEN_MIN:   cfg_prdata = DataW'(norm_green_min_r);
      REG_NORM_BLUE_MAX:    cfg_prdata = DataW'(norm_blue_max_r);
      REG_ABS_RED_MIN:      cfg_prdata = DataW'(abs_red_min_r);
      REG_ABS_GREEN_MIN:    cfg_prdata = DataW'(abs_green_min_r);
      REG_ABS_BLUE_MAX:     cfg_prdata = DataW'(abs_blue_max_r);
      REG_WHITE_MIN:        cfg_prdata = DataW'(white_min_r);
      REG_GREEN_EXCESS_MIN: cfg_prdata = DataW'(green_excess_min_r);
      default:              cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Handshake. The result register loads when it is empty or being drained;
  // stage one moves forward whenever it holds a pixel and the result
  // register can load, and it accepts a new pixel when it is empty or moving.
  // ---------------------------------------------------------------------
  logic s1_valid_r;
  logic out_valid_r;
  logic out_load;
  logic s1_move;
  logic in_take;

  assign out_load     = !out_valid_r || out_res.ready;
  assign s1_move      = s1_valid_r && out_load;
  assign in_pix.ready = !s1_valid_r || out_load;
  assign in_take      = in_pix.valid && in_pix.ready;

  // ---------------------------------------------------------------------
  // Stage one: everything that does not depend on the column state.
  // The share tests are cross multiplied: "red share above norm_red_min"
  // becomes 100*red > norm_red_min*sum, so no division is needed.
  // ---------------------------------------------------------------------
  logic [SumW-1:0]     pix_sum;
  logic [ExcessW-1:0]  excess_lhs, excess_rhs;

  logic [PixProdW-1:0] red_pct_r, grn_pct_r, blue_pct_r;
  logic [ThrProdW-1:0] red_thr_r, grn_thr_r, blue_thr_r;
  logic                sum_nz_r;
  logic                abs_yellow_r;
  logic                excess_r;
  logic                white_r;
  logic                start_r;

  assign pix_sum    = SumW'(in_pix.red) + SumW'(in_pix.grn) + SumW'(in_pix.blue);
  assign excess_lhs = ExcessW'({in_pix.grn, 1'b0});
  assign excess_rhs = ExcessW'(in_pix.red) + ExcessW'(in_pix.blue)
                    + ExcessW'({green_excess_min_r, 1'b0});

  always_ff @(posedge clk) begin
    if (in_take) begin
      red_pct_r    <= PixProdW'(in_pix.red)  * PixProdW'(Hundred);
      grn_pct_r    <= PixProdW'(in_pix.grn)  * PixProdW'(Hundred);
      blue_pct_r   <= PixProdW'(in_pix.blue) * PixProdW'(Hundred);
      red_thr_r    <= ThrProdW'(norm_red_min_r)   * ThrProdW'(pix_sum);
      grn_thr_r    <= ThrProdW'(norm_green_min_r) * ThrProdW'(pix_sum);
      blue_thr_r   <= ThrProdW'(norm_blue_max_r)  * ThrProdW'(pix_sum);
      sum_nz_r     <= (pix_sum != '0);
      abs_yellow_r <= (in_pix.red > abs_red_min_r) && (in_pix.grn > abs_green_min_r)
                   && (in_pix.blue < abs_blue_max_r);
      excess_r     <= (excess_lhs > excess_rhs);
      white_r      <= (in_pix.red > white_min_r) && (in_pix.grn > white_min_r)
                   && (in_pix.blue > white_min_r);
      start_r      <= in_pix.column_start;
    end
  end

  // ---------------------------------------------------------------------
  // Stage two: finish the yellow test and apply the column state.
  // A column start resets the run before this pixel is classified; the
  // state after reset behaves as the start of a column.
  // ---------------------------------------------------------------------
  logic [RunW-1:0] green_run_r, green_run_nxt, run_cur;
  logic            in_background_r, in_background_nxt, bg_cur;
  logic            norm_yellow, yellow, green, white;

  always_comb begin
    norm_yellow = sum_nz_r
               && (ThrProdW'(red_pct_r) > red_thr_r)
               && (ThrProdW'(grn_pct_r) > grn_thr_r)
               && (ThrProdW'(blue_pct_r) < blue_thr_r);
    yellow  = norm_yellow || abs_yellow_r;
    bg_cur  = start_r ? 1'b1 : in_background_r;
    run_cur = start_r ? '0 : green_run_r;
    green   = bg_cur && excess_r && !yellow;
    white   = !bg_cur && white_r;

    green_run_nxt     = run_cur;
    in_background_nxt = bg_cur;
    if (green) begin
      // The counter saturates at its top value.
      green_run_nxt     = (run_cur == RunMax) ? RunMax : run_cur + 1'b1;
      in_background_nxt = (green_run_nxt <= RunLimit);
    end
  end

  logic line_white_r, yellow_mask_r, field_green_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r      <= 1'b0;
      out_valid_r     <= 1'b0;
      green_run_r     <= '0;
      in_background_r <= 1'b1;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_move) begin
        out_valid_r     <= 1'b1;
        green_run_r     <= green_run_nxt;
        in_background_r <= in_background_nxt;
      end else if (out_res.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      line_white_r  <= white;
      yellow_mask_r <= yellow;
      field_green_r <= green;
    end
  end

  assign out_res.valid       = out_valid_r;
  assign out_res.line_white  = line_white_r;
  assign out_res.yellow_mask = yellow_mask_r;
  assign out_res.field_green = field_green_r;

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  // A pixel is counted green only in background mode, and only out of
  // background mode can it be white, so the two never come together.
  a_white_xor_green: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(line_white_r && field_green_r))
    else $error("line_white and field_green both set");

  // Once the run passes the limit the column has left background mode.
  a_run_ends_bg: assert property (@(posedge clk) disable iff (!rst_n)
    (green_run_r > RunLimit) |-> !in_background_r)
    else $error("green run above limit while still in background mode");

  // A pixel in stage one that cannot move on stays there.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_load) |=> s1_valid_r)
    else $error("stage one pixel lost during a stall");

  // The column state changes only when a pixel is classified.
  a_state_moves_with_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_move |=> ($stable(green_run_r) && $stable(in_background_r)))
    else $error("column state changed without a pixel");

endmodule

`default_nettype wire
